### src/ead_pkg.sv
// Shared widths, stage codes, register indexes and fixed-point constants
// for the exponential envelope generator. No dependencies.
package ead_pkg;

    localparam int NUM_STAGES = 5;

    localparam int LVL_W   = 24;  // Q1.23 level
    localparam int MUL_W   = 32;  // serial multiplier operand width
    localparam int LEN_W   = 26;  // stage length in samples
    localparam int LOG_W   = 29;  // 5 integer bits, 24 fraction bits
    localparam int FRAC_W  = 24;
    localparam int NUM_W   = 35;  // dividend width
    localparam int MANT_W  = 31;  // normalized mantissa, Q1.30

    localparam logic [2:0] STG_OFF     = 3'd0;
    localparam logic [2:0] STG_ATTACK  = 3'd1;
    localparam logic [2:0] STG_DECAY   = 3'd2;
    localparam logic [2:0] STG_SUSTAIN = 3'd3;
    localparam logic [2:0] STG_RELEASE = 3'd4;

    localparam logic [2:0] REG_SAMPLE_RATE   = 3'd0;
    localparam logic [2:0] REG_ATTACK_TIME   = 3'd1;
    localparam logic [2:0] REG_DECAY_TIME    = 3'd2;
    localparam logic [2:0] REG_SUSTAIN_LEVEL = 3'd3;
    localparam logic [2:0] REG_RELEASE_TIME  = 3'd4;
    localparam logic [2:0] REG_MINIMUM_LEVEL = 3'd5;

    localparam logic [LVL_W-1:0] FULL_SCALE = 24'd8388608;
    localparam logic [31:0]      ONE_Q30    = 32'h4000_0000;
    localparam logic [31:0]      LN2_Q32    = 32'd2977044472;

endpackage

### src/ead_mul.sv
// Bit-serial shift-add multiplier, 32 x 32 -> 64, one multiplier bit per cycle.
// Depends on ead_pkg.
module ead_mul (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [ead_pkg::MUL_W-1:0]     i_a,
    input  logic [ead_pkg::MUL_W-1:0]     i_b,
    output logic                          o_done,
    output logic [2*ead_pkg::MUL_W-1:0]   o_prod
);

    logic [2*ead_pkg::MUL_W-1:0] r_acc;
    logic [ead_pkg::MUL_W-1:0]   r_a;
    logic [ead_pkg::MUL_W-1:0]   r_b;
    logic [4:0]                  r_cnt;
    logic                        r_busy;
    logic                        r_done;
    logic [ead_pkg::MUL_W:0]     w_sum;

    assign w_sum = {1'b0, r_acc[2*ead_pkg::MUL_W-1:ead_pkg::MUL_W]}
                 + (r_b[0] ? {1'b0, r_a} : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_a    <= i_a;
                r_b    <= i_b;
                r_acc  <= '0;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_acc <= {w_sum, r_acc[ead_pkg::MUL_W-1:1]};
                r_b   <= r_b >> 1;
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

### src/ead_div.sv
// Restoring divider, one quotient bit per cycle, 35-bit dividend by 26-bit divisor.
// Depends on ead_pkg.
module ead_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [ead_pkg::NUM_W-1:0]   i_num,
    input  logic [ead_pkg::LEN_W-1:0]   i_den,
    output logic                        o_done,
    output logic [ead_pkg::NUM_W-1:0]   o_quot
);

    logic [ead_pkg::NUM_W-1:0] r_num;
    logic [ead_pkg::NUM_W-1:0] r_quot;
    logic [ead_pkg::LEN_W-1:0] r_den;
    logic [ead_pkg::LEN_W-1:0] r_rem;
    logic [5:0]                r_cnt;
    logic                      r_busy;
    logic                      r_done;
    logic [ead_pkg::LEN_W:0]   w_trial;
    logic                      w_fit;

    assign w_trial = {r_rem, r_num[ead_pkg::NUM_W-1]};
    assign w_fit   = (w_trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_num  <= i_num;
                r_den  <= i_den;
                r_rem  <= '0;
                r_quot <= '0;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem  <= w_fit ? ead_pkg::LEN_W'(w_trial - {1'b0, r_den})
                                : w_trial[ead_pkg::LEN_W-1:0];
                r_quot <= {r_quot[ead_pkg::NUM_W-2:0], w_fit};
                r_num  <= r_num << 1;
                r_cnt  <= r_cnt + 6'd1;
                if (r_cnt == 6'(ead_pkg::NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

### src/exponential_adsr_envelope.sv
// Exponential ADSR envelope generator: top level with sequencer and registers.
// Depends on ead_pkg, ead_mul (serial multiplier) and ead_div (serial divider).
//
//   channel   direction  handshake                  payload
//   request   in         i_in_valid / o_in_stall    i_req_type, i_target_stage
//   result    out        o_out_valid / i_out_stall  o_level, o_stage
//   config    in         APB psel/penable/pready    paddr, pwdata, prdata
//
// A tick inside a running stage shows its result after one pass of the
// bit-serial multiplier. A stage entry into attack, decay or release runs a
// length multiply, two logarithms of up to 23 normalize shifts and 24 squarings
// each on the shared serial multiplier, ln 2 scaling and a 35-step divide. A
// tick that ends a stage adds one more multiply pass. Entering off or sustain
// by command needs no multiply; ticks in off or sustain and dropped commands
// go straight to the result state. One request is in work at a time.
// Reset is synchronous: stage off, level zero, multiplier 1.0, registers at
// their defaults. A stalled result holds in the output register; the
// sequencer waits there until it is taken.
module exponential_adsr_envelope (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_req_type,
    input  logic [2:0]  i_target_stage,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [23:0] o_level,
    output logic [2:0]  o_stage,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    typedef enum logic [3:0] {
        S_IDLE, S_ENTER, S_LENW, S_NORM, S_SQ, S_SQW, S_LOGD,
        S_LNW, S_DIVW, S_TICK, S_TICKW, S_DONE
    } t_state;

    t_state r_state;

    // configuration
    logic [17:0] r_sample_rate;
    logic [23:0] r_attack_time, r_decay_time, r_sustain_level;
    logic [23:0] r_release_time, r_minimum_level;

    // envelope state
    logic [2:0]                  r_stage;
    logic [ead_pkg::LVL_W-1:0]   r_level;
    logic [31:0]                 r_mult;
    logic [31:0]                 r_count;
    logic [ead_pkg::LEN_W-1:0]   r_len;

    // sequencer working registers
    logic                        r_do_tick;
    logic [2:0]                  r_next_stage;
    logic [ead_pkg::LVL_W-1:0]   r_end_lvl;
    logic [ead_pkg::MANT_W-1:0]  r_m;
    logic [4:0]                  r_top;
    logic [ead_pkg::FRAC_W-1:0]  r_frac;
    logic [4:0]                  r_step;
    logic                        r_log_sel;
    logic [ead_pkg::LOG_W-1:0]   r_log_s;
    logic                        r_down;
    logic [ead_pkg::MUL_W-1:0]   r_mul_a, r_mul_b;
    logic                        r_mul_start;
    logic [ead_pkg::NUM_W-1:0]   r_div_num;
    logic                        r_div_start;

    logic                        r_out_valid;
    logic [ead_pkg::LVL_W-1:0]   r_out_level;
    logic [2:0]                  r_out_stage;

    logic                          w_mul_done;
    logic [2*ead_pkg::MUL_W-1:0]   w_prod;
    logic                          w_div_done;
    logic [ead_pkg::NUM_W-1:0]     w_quot;

    logic                        w_accept;
    logic                        w_cfg_wr;
    logic [ead_pkg::LVL_W-1:0]   w_floor, w_sus, w_decay_end;
    logic [ead_pkg::LEN_W-1:0]   w_len;
    logic [31:0]                 w_sq;
    logic [ead_pkg::LOG_W-1:0]   w_log;
    logic                        w_le_lt;
    logic [33:0]                 w_tick_p;
    t_state                      w_after_entry;

    ead_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_mul_start),
        .i_a     (r_mul_a),
        .i_b     (r_mul_b),
        .o_done  (w_mul_done),
        .o_prod  (w_prod)
    );

    ead_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_start),
        .i_num   (r_div_num),
        .i_den   (r_len),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    assign o_in_stall = (r_state != S_IDLE);
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_cfg_wr   = psel && penable && pwrite && pready;
    assign pready     = 1'b1;

    // Clamp the level registers to full scale where they are used.
    assign w_floor = (r_minimum_level > ead_pkg::FULL_SCALE) ? ead_pkg::FULL_SCALE
                                                              : r_minimum_level;
    assign w_sus   = (r_sustain_level > ead_pkg::FULL_SCALE) ? ead_pkg::FULL_SCALE
                                                              : r_sustain_level;
    assign w_decay_end = (w_sus > w_floor) ? w_sus : w_floor;

    assign w_len    = w_prod[41:16];           // (time * rate) >> 16
    assign w_sq     = w_prod[61:30];           // Q2.30 square of the Q1.30 mantissa, truncated
    assign w_log    = {r_top, r_frac};
    assign w_le_lt  = (w_log < r_log_s);
    assign w_tick_p = w_prod[63:30];
    assign w_after_entry = r_do_tick ? S_TICK : S_DONE;

    always_comb begin
        case (paddr[4:2])
            ead_pkg::REG_SAMPLE_RATE:   prdata = {14'd0, r_sample_rate};
            ead_pkg::REG_ATTACK_TIME:   prdata = {8'd0, r_attack_time};
            ead_pkg::REG_DECAY_TIME:    prdata = {8'd0, r_decay_time};
            ead_pkg::REG_SUSTAIN_LEVEL: prdata = {8'd0, r_sustain_level};
            ead_pkg::REG_RELEASE_TIME:  prdata = {8'd0, r_release_time};
            ead_pkg::REG_MINIMUM_LEVEL: prdata = {8'd0, r_minimum_level};
            default:                    prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_sample_rate   <= 18'd48000;
            r_attack_time   <= 24'd655;
            r_decay_time    <= 24'd32768;
            r_sustain_level <= 24'd4194304;
            r_release_time  <= 24'd65536;
            r_minimum_level <= 24'd839;
            r_stage         <= ead_pkg::STG_OFF;
            r_level         <= '0;
            r_mult          <= ead_pkg::ONE_Q30;
            r_count         <= '0;
            r_len           <= '0;
            r_mul_start     <= 1'b0;
            r_div_start     <= 1'b0;
            r_out_valid     <= 1'b0;
        end else begin
            r_mul_start <= 1'b0;
            r_div_start <= 1'b0;

            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            if (w_cfg_wr) begin
                unique case (paddr[4:2])
                    ead_pkg::REG_SAMPLE_RATE:   r_sample_rate   <= pwdata[17:0];
                    ead_pkg::REG_ATTACK_TIME:   r_attack_time   <= pwdata[23:0];
                    ead_pkg::REG_DECAY_TIME:    r_decay_time    <= pwdata[23:0];
                    ead_pkg::REG_SUSTAIN_LEVEL: r_sustain_level <= pwdata[23:0];
                    ead_pkg::REG_RELEASE_TIME:  r_release_time  <= pwdata[23:0];
                    ead_pkg::REG_MINIMUM_LEVEL: r_minimum_level <= pwdata[23:0];
                    default: ;
                endcase
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_do_tick <= !i_req_type;
                        if (i_req_type) begin
                            // Force a stage; drop codes beyond release.
                            if (i_target_stage < 3'(ead_pkg::NUM_STAGES)) begin
                                r_next_stage <= i_target_stage;
                                r_state      <= S_ENTER;
                            end else begin
                                r_state <= S_DONE;
                            end
                        end else if (r_stage == ead_pkg::STG_OFF ||
                                     r_stage == ead_pkg::STG_SUSTAIN) begin
                            r_state <= S_DONE;
                        end else if (r_count >= {6'd0, r_len}) begin
                            // Stage over: advance in cyclic order.
                            r_next_stage <= (r_stage == ead_pkg::STG_RELEASE)
                                          ? ead_pkg::STG_OFF : r_stage + 3'd1;
                            r_state      <= S_ENTER;
                        end else begin
                            r_state <= S_TICK;
                        end
                    end
                end

                S_ENTER: begin
                    r_stage <= r_next_stage;
                    r_count <= '0;
                    r_mul_b <= {14'd0, r_sample_rate};
                    unique case (r_next_stage)
                        ead_pkg::STG_ATTACK: begin
                            r_level     <= w_floor;
                            r_end_lvl   <= ead_pkg::FULL_SCALE;
                            r_mul_a     <= {8'd0, r_attack_time};
                            r_mul_start <= 1'b1;
                            r_state     <= S_LENW;
                        end
                        ead_pkg::STG_DECAY: begin
                            r_level     <= ead_pkg::FULL_SCALE;
                            r_end_lvl   <= (w_decay_end == '0) ? 24'd1 : w_decay_end;
                            r_mul_a     <= {8'd0, r_decay_time};
                            r_mul_start <= 1'b1;
                            r_state     <= S_LENW;
                        end
                        ead_pkg::STG_RELEASE: begin
                            // Keep the level; ramp toward the floor.
                            r_end_lvl   <= (w_floor == '0) ? 24'd1 : w_floor;
                            r_mul_a     <= {8'd0, r_release_time};
                            r_mul_start <= 1'b1;
                            r_state     <= S_LENW;
                        end
                        ead_pkg::STG_SUSTAIN: begin
                            r_len   <= '0;
                            r_level <= w_sus;
                            r_mult  <= ead_pkg::ONE_Q30;
                            r_state <= w_after_entry;
                        end
                        default: begin
                            r_len   <= '0;
                            r_level <= '0;
                            r_mult  <= ead_pkg::ONE_Q30;
                            r_state <= w_after_entry;
                        end
                    endcase
                end

                S_LENW: begin
                    if (w_mul_done) begin
                        r_len <= w_len;
                        if (r_level == '0 || w_len == '0) begin
                            r_mult  <= ead_pkg::ONE_Q30;
                            r_state <= w_after_entry;
                        end else begin
                            r_m       <= {r_level, 7'd0};
                            r_top     <= 5'd23;
                            r_log_sel <= 1'b0;
                            r_state   <= S_NORM;
                        end
                    end
                end

                // Shift the mantissa up one place a cycle to find the top bit.
                S_NORM: begin
                    if (r_m[ead_pkg::MANT_W-1]) begin
                        r_frac  <= '0;
                        r_step  <= '0;
                        r_state <= S_SQ;
                    end else begin
                        r_m   <= r_m << 1;
                        r_top <= r_top - 5'd1;
                    end
                end

                S_SQ: begin
                    r_mul_a     <= {1'b0, r_m};
                    r_mul_b     <= {1'b0, r_m};
                    r_mul_start <= 1'b1;
                    r_state     <= S_SQW;
                end

                // Each square yields one fraction bit of the logarithm.
                S_SQW: begin
                    if (w_mul_done) begin
                        r_frac <= {r_frac[ead_pkg::FRAC_W-2:0], w_sq[31]};
                        r_m    <= w_sq[31] ? w_sq[31:1] : w_sq[30:0];
                        if (r_step == 5'(ead_pkg::FRAC_W - 1)) begin
                            r_state <= S_LOGD;
                        end else begin
                            r_step  <= r_step + 5'd1;
                            r_state <= S_SQ;
                        end
                    end
                end

                S_LOGD: begin
                    if (!r_log_sel) begin
                        r_log_s   <= w_log;
                        r_m       <= {r_end_lvl, 7'd0};
                        r_top     <= 5'd23;
                        r_log_sel <= 1'b1;
                        r_state   <= S_NORM;
                    end else begin
                        r_down      <= w_le_lt;
                        r_mul_a     <= ead_pkg::LN2_Q32;
                        r_mul_b     <= {3'd0, w_le_lt ? r_log_s - w_log : w_log - r_log_s};
                        r_mul_start <= 1'b1;
                        r_state     <= S_LNW;
                    end
                end

                // Scale log2 difference by ln 2, move Q.24 to Q.30, then divide.
                S_LNW: begin
                    if (w_mul_done) begin
                        r_div_num   <= {w_prod[60:32], 6'd0};
                        r_div_start <= 1'b1;
                        r_state     <= S_DIVW;
                    end
                end

                S_DIVW: begin
                    if (w_div_done) begin
                        if (!r_down) begin
                            r_mult <= (w_quot > 35'h0_3FFF_FFFF) ? 32'h7FFF_FFFF
                                    : ead_pkg::ONE_Q30 + w_quot[31:0];
                        end else begin
                            r_mult <= (w_quot > 35'h0_C000_0000) ? 32'h8000_0000
                                    : ead_pkg::ONE_Q30 - w_quot[31:0];
                        end
                        r_state <= w_after_entry;
                    end
                end

                S_TICK: begin
                    if (r_count != 32'hFFFF_FFFF) begin
                        r_count <= r_count + 32'd1;
                    end
                    if (r_mult[31]) begin
                        r_level <= '0;
                        r_state <= S_DONE;
                    end else begin
                        r_mul_a     <= r_mult;
                        r_mul_b     <= {8'd0, r_level};
                        r_mul_start <= 1'b1;
                        r_state     <= S_TICKW;
                    end
                end

                S_TICKW: begin
                    if (w_mul_done) begin
                        r_level <= (w_tick_p > 34'(ead_pkg::FULL_SCALE))
                                 ? ead_pkg::FULL_SCALE : w_tick_p[23:0];
                        r_state <= S_DONE;
                    end
                end

                // Hold here until the output register is free.
                S_DONE: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid <= 1'b1;
                        r_out_level <= r_level;
                        r_out_stage <= r_stage;
                        r_state     <= S_IDLE;
                    end
                end

                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_level     = r_out_level;
    assign o_stage     = r_out_stage;

endmodule

### tb/sv/testbench.sv
// Self-checking testbench for the exponential ADSR envelope generator.
// It depends on ead_pkg and exponential_adsr_envelope. A built-in predictor
// computes the level and stage expected after each request.
`timescale 1ns / 100ps

module testbench;

    localparam logic REQ_TICK  = 1'b0;
    localparam logic REQ_ENTER = 1'b1;
    localparam int   CYCLE_LIMIT = 12_000_000;
    localparam int   LONG_HOLD   = 6000;

    typedef struct {
        logic       kind;
        logic [2:0] target;
        int         gap;
    } t_request;

    typedef struct {
        logic [23:0] level;
        logic [2:0]  stage;
    } t_envelope_out;

    // DUT connections; every input starts at a known value
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic        i_req_type = 1'b0;
    logic [2:0]  i_target_stage = 3'd0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [23:0] o_level;
    logic [2:0]  o_stage;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = 5'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    exponential_adsr_envelope dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .i_req_type(i_req_type), .i_target_stage(i_target_stage),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_level(o_level), .o_stage(o_stage),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // Shadow copy of the configuration registers
    logic [31:0] cfg_rate, cfg_attack, cfg_decay, cfg_sustain, cfg_release, cfg_floor;
    // Shadow copy of the envelope state
    logic [2:0]  env_stage;
    logic [31:0] env_level, env_mult, env_count, env_len;

    t_request      pending_requests[$];
    t_envelope_out expected_levels[$];
    int            mismatches = 0;
    int            results_seen = 0;
    int            cycles = 0;
    bit            no_idle = 1'b0;   // phase flag: back-to-back traffic on both sides

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------
    function automatic logic [31:0] clamp_fs(logic [31:0] v);
        return (v > 32'(ead_pkg::FULL_SCALE)) ? 32'(ead_pkg::FULL_SCALE) : v;
    endfunction

    // log2 with 24 fraction bits: top bit position plus repeated squaring
    function automatic logic [31:0] log2_q24(logic [31:0] x);
        logic [31:0]          top;
        logic [31:0]          frac;
        logic [63:0]          m;
        top = 0;
        frac = 0;
        while (top < 31 && (x >> (top + 1)) != 0)
            top++;
        m = 64'(x) << (30 - top);
        for (int i = 0; i < 24; i++) begin
            m = (m * m) >> 30;
            frac = frac << 1;
            if (m >= (64'd2 << 30)) begin
                m = m >> 1;
                frac = frac | 32'd1;
            end
        end
        return (top << 24) | frac;
    endfunction

    function automatic logic [31:0] ramp_rate(logic [31:0] from_lvl, logic [31:0] to_lvl,
                                              logic [31:0] len);
        logic [31:0] ls, le, mag;
        logic        down;
        logic [63:0] q;
        if (from_lvl == 0 || len == 0)
            return ead_pkg::ONE_Q30;
        if (to_lvl == 0)
            to_lvl = 1;
        ls = log2_q24(from_lvl);
        le = log2_q24(to_lvl);
        down = le < ls;
        mag = down ? ls - le : le - ls;
        q = (((64'(mag) * 64'(ead_pkg::LN2_Q32)) >> 32) << 6) / 64'(len);
        if (!down)
            return (q > 64'h3FFF_FFFF) ? 32'h7FFF_FFFF : ead_pkg::ONE_Q30 + q[31:0];
        if (q > 64'hC000_0000)
            return 32'h8000_0000;
        return ead_pkg::ONE_Q30 - q[31:0];
    endfunction

    function automatic logic [31:0] samples_for(logic [31:0] t);
        logic [63:0] p;
        p = (64'(t) * 64'(cfg_rate)) >> 16;
        return p[31:0];
    endfunction

    task automatic enter_stage(logic [2:0] s);
        logic [31:0] floor_lvl, sus;
        floor_lvl = clamp_fs(cfg_floor);
        sus = clamp_fs(cfg_sustain);
        env_stage = s;
        env_count = 0;
        case (s)
            ead_pkg::STG_ATTACK: begin
                env_len = samples_for(cfg_attack);
                env_level = floor_lvl;
                env_mult = ramp_rate(env_level, 32'(ead_pkg::FULL_SCALE), env_len);
            end
            ead_pkg::STG_DECAY: begin
                env_len = samples_for(cfg_decay);
                env_level = 32'(ead_pkg::FULL_SCALE);
                env_mult = ramp_rate(env_level, (sus > floor_lvl) ? sus : floor_lvl, env_len);
            end
            ead_pkg::STG_SUSTAIN: begin
                env_len = 0;
                env_level = sus;
                env_mult = ead_pkg::ONE_Q30;
            end
            ead_pkg::STG_RELEASE: begin
                env_len = samples_for(cfg_release);
                env_mult = ramp_rate(env_level, floor_lvl, env_len);
            end
            default: begin
                env_len = 0;
                env_level = 0;
                env_mult = ead_pkg::ONE_Q30;
            end
        endcase
    endtask

    task automatic predict_envelope(logic kind, logic [2:0] target);
        t_envelope_out r;
        logic [63:0]   p;
        if (kind == REQ_ENTER) begin
            if (target < ead_pkg::NUM_STAGES)
                enter_stage(target);
        end else if (env_stage != ead_pkg::STG_OFF && env_stage != ead_pkg::STG_SUSTAIN) begin
            if (env_count >= env_len)
                enter_stage((env_stage == ead_pkg::STG_RELEASE) ? ead_pkg::STG_OFF
                                                                 : env_stage + 3'd1);
            if (env_mult[31]) begin
                env_level = 0;
            end else begin
                p = (64'(env_level) * 64'(env_mult)) >> 30;
                env_level = (p > 64'(ead_pkg::FULL_SCALE)) ? 32'(ead_pkg::FULL_SCALE)
                                                           : p[31:0];
            end
            if (env_count != 32'hFFFF_FFFF)
                env_count++;
        end
        r.level = env_level[23:0];
        r.stage = env_stage;
        expected_levels.push_back(r);
    endtask

    // ---------------------------------------------------------------
    // Request driver: pops the queue, waits each request's drawn gap
    // ---------------------------------------------------------------
    int gap_count = 0;

    always @(posedge i_clk) begin
        t_request nxt;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                // request taken at this edge: predict before anything else moves
                predict_envelope(i_req_type, i_target_stage);
                if (pending_requests.size() != 0 && pending_requests[0].gap == 0) begin
                    // keep valid high for a back-to-back request
                    nxt = pending_requests.pop_front();
                    i_req_type <= nxt.kind;
                    i_target_stage <= nxt.target;
                end else begin
                    i_in_valid <= 1'b0;
                    gap_count <= 0;
                end
            end else if (!i_in_valid && pending_requests.size() != 0) begin
                if (gap_count >= pending_requests[0].gap) begin
                    nxt = pending_requests.pop_front();
                    i_req_type <= nxt.kind;
                    i_target_stage <= nxt.target;
                    i_in_valid <= 1'b1;
                end else begin
                    gap_count <= gap_count + 1;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Result monitor and receiver stall generator
    // ---------------------------------------------------------------
    int rx_wait = 0;
    int hold_left = 0;

    always @(posedge i_clk) begin
        t_envelope_out exp_r;
        int            wait_n;
        int            hold_n;
        wait_n = rx_wait;
        hold_n = (hold_left > 0) ? hold_left - 1 : 0;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen <= results_seen + 1;
            if (expected_levels.size() == 0) begin
                mismatches <= mismatches + 1;
                if (mismatches < 10)
                    $display("Unexpected result: level=%0d stage=%0d", o_level, o_stage);
            end else begin
                exp_r = expected_levels.pop_front();
                if (exp_r.level !== o_level || exp_r.stage !== o_stage) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("Mismatch: expected level=%0d stage=%0d, got level=%0d stage=%0d",
                                 exp_r.level, exp_r.stage, o_level, o_stage);
                end
            end
            wait_n = no_idle ? 0 : $urandom_range(0, 15);
            // one long hold-off so the block fills up and stalls its input
            if (results_seen == 300)
                hold_n = LONG_HOLD;
        end else if (wait_n > 0) begin
            wait_n = wait_n - 1;
        end
        rx_wait <= wait_n;
        hold_left <= hold_n;
        i_out_stall <= (wait_n != 0) || (hold_n != 0);
    end

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------
    task automatic reg_write(logic [2:0] idx, logic [31:0] val);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            ead_pkg::REG_SAMPLE_RATE:   cfg_rate = val & 32'h3FFFF;
            ead_pkg::REG_ATTACK_TIME:   cfg_attack = val & 32'hFFFFFF;
            ead_pkg::REG_DECAY_TIME:    cfg_decay = val & 32'hFFFFFF;
            ead_pkg::REG_SUSTAIN_LEVEL: cfg_sustain = val & 32'hFFFFFF;
            ead_pkg::REG_RELEASE_TIME:  cfg_release = val & 32'hFFFFFF;
            ead_pkg::REG_MINIMUM_LEVEL: cfg_floor = val & 32'hFFFFFF;
            default: ;
        endcase
    endtask

    task automatic queue_request(logic kind, logic [2:0] target);
        t_request r;
        r.kind = kind;
        r.target = target;
        r.gap = no_idle ? 0 : $urandom_range(0, 15);
        pending_requests.push_back(r);
    endtask

    // Hold until every request is sent and every result taken
    task automatic drain;
        wait (pending_requests.size() == 0 && !i_in_valid && expected_levels.size() == 0);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic configure(logic [31:0] rate, logic [31:0] att, logic [31:0] dec,
                             logic [31:0] sus, logic [31:0] rel, logic [31:0] flr);
        drain();
        reg_write(ead_pkg::REG_SAMPLE_RATE, rate);
        reg_write(ead_pkg::REG_ATTACK_TIME, att);
        reg_write(ead_pkg::REG_DECAY_TIME, dec);
        reg_write(ead_pkg::REG_SUSTAIN_LEVEL, sus);
        reg_write(ead_pkg::REG_RELEASE_TIME, rel);
        reg_write(ead_pkg::REG_MINIMUM_LEVEL, flr);
    endtask

    // Stage time that gives roughly 0..max_len samples at the current rate
    function automatic logic [31:0] short_time(int max_len);
        logic [31:0] t;
        t = (32'(max_len) * 32'd65536) / cfg_rate;
        if (t > 32'hFFFFFF)
            t = 32'hFFFFFF;
        return $urandom_range(0, t);
    endfunction

    // Random notes: attack, ticks, maybe an early release, ticks; plus noise
    task automatic random_notes(int count);
        int n;
        int ticks;
        n = 0;
        while (n < count) begin
            if ($urandom_range(0, 7) == 0) begin
                queue_request(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)));
                n++;
            end else begin
                queue_request(REQ_ENTER, ead_pkg::STG_ATTACK);
                ticks = $urandom_range(0, 40);
                for (int i = 0; i < ticks; i++)
                    queue_request(REQ_TICK, 3'($urandom_range(0, 7)));
                n += ticks + 1;
                if ($urandom_range(0, 2) == 0) begin
                    queue_request(REQ_ENTER, ead_pkg::STG_RELEASE);
                    ticks = $urandom_range(0, 20);
                    for (int i = 0; i < ticks; i++)
                        queue_request(REQ_TICK, 3'd0);
                    n += ticks + 1;
                end
            end
        end
    endtask

    initial begin
        logic [31:0] rate;
        cfg_rate = 48000;
        cfg_attack = 655;
        cfg_decay = 32768;
        cfg_sustain = 4194304;
        cfg_release = 65536;
        cfg_floor = 839;
        env_stage = ead_pkg::STG_OFF;
        env_level = 0;
        env_mult = ead_pkg::ONE_Q30;
        env_count = 0;
        env_len = 0;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset settings, every stage, illegal targets, ticks everywhere
        queue_request(REQ_TICK, 3'd0);
        queue_request(REQ_ENTER, ead_pkg::STG_ATTACK);
        queue_request(REQ_TICK, 3'd7);
        queue_request(REQ_TICK, 3'd0);
        queue_request(REQ_ENTER, ead_pkg::STG_DECAY);
        queue_request(REQ_TICK, 3'd0);
        queue_request(REQ_ENTER, ead_pkg::STG_SUSTAIN);
        queue_request(REQ_TICK, 3'd0);
        queue_request(REQ_ENTER, 3'd5);
        queue_request(REQ_ENTER, 3'd6);
        queue_request(REQ_ENTER, 3'd7);
        queue_request(REQ_ENTER, ead_pkg::STG_RELEASE);
        queue_request(REQ_TICK, 3'd0);
        queue_request(REQ_ENTER, ead_pkg::STG_OFF);
        queue_request(REQ_TICK, 3'd0);

        // Zero-length stages: each tick in attack, decay or release moves on to the next stage
        configure(1, 0, 0, 0, 0, 1);
        queue_request(REQ_ENTER, ead_pkg::STG_ATTACK);
        for (int i = 0; i < 5; i++)
            queue_request(REQ_TICK, 3'd0);
        queue_request(REQ_ENTER, ead_pkg::STG_RELEASE);
        queue_request(REQ_TICK, 3'd0);

        // Extremes: longest stages, levels above full scale, then zero floor
        configure(192000, 32'hFFFFFF, 32'hFFFFFF, 32'hFFFFFF, 32'hFFFFFF, 32'hFFFFFF);
        random_notes(20);
        configure(262143, 1, 2, 8388608, 3, 0);
        random_notes(30);

        // Pause the sender until all results are in, then run without idling
        drain();
        no_idle = 1'b1;
        configure(48000, 655, 32768, 4194304, 65536, 839);
        random_notes(40);
        drain();
        no_idle = 1'b0;

        // Random phases with short stages so that notes run to completion
        for (int ph = 0; ph < 8; ph++) begin
            drain();
            rate = $urandom_range(1, 192000);
            cfg_rate = rate;
            configure(rate, short_time(30), short_time(30),
                      $urandom_range(0, 9000000), short_time(30),
                      $urandom_range(0, 3) == 0 ? $urandom_range(0, 32'hFFFFFF)
                                                : $urandom_range(1, 8388608));
            no_idle = (ph == 3);
            random_notes(65);
        end

        drain();
        repeat (100) @(posedge i_clk);
        if (mismatches == 0 && expected_levels.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

### sim.f
src/ead_pkg.sv
src/ead_mul.sv
src/ead_div.sv
src/exponential_adsr_envelope.sv
tb/sv/testbench.sv
